// ===== rtl/blpm_pkg.sv =====
// ----------------------------------------------------------------------------
// blpm_pkg
// Shared types and constants of the binary trie prefix match block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blpm_pkg;

  // key length walked per lookup, most significant bit first
  localparam int KEY_BITS = 32;
  localparam int LVL_W    = 6;
  localparam int PATH_W   = 5;
  localparam logic [7:0] NO_ACTION = 8'h20;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_FETCH,
    S_POP,
    S_CREATE,
    S_FIN,
    S_UP,
    S_UPLD,
    S_DONE
  } state_t;

  // address bit that picks the child at a level below KEY_BITS
  function automatic logic key_bit(input logic [KEY_BITS-1:0] a,
                                   input logic [LVL_W-1:0] l);
    logic [PATH_W-1:0] sh;
    sh = ~l[PATH_W-1:0];
    return a[sh];
  endfunction

endpackage

// ===== rtl/blpm_in_if.sv =====
// ----------------------------------------------------------------------------
// blpm_in_if
// Request channel: one word per add, find or remove operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [5:0]  prefix_len;
  logic [7:0]  action;

  modport source (output valid, mode, address, prefix_len, action, input ready);
  modport sink   (input valid, mode, address, prefix_len, action, output ready);
endinterface

// ===== rtl/blpm_out_if.sv =====
// ----------------------------------------------------------------------------
// blpm_out_if
// Result channel: one word per operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blpm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] found_action;
  logic [5:0] match_depth;
  logic [9:0] node_count;

  modport source (output valid, status, found_action, match_depth, node_count,
                  input ready);
  modport sink   (input valid, status, found_action, match_depth, node_count,
                  output ready);
endinterface

// ===== rtl/blpm_ram.sv =====
// ----------------------------------------------------------------------------
// blpm_ram
// Simple dual port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

// ===== rtl/binary_trie_longest_prefix_match.sv =====
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// Operation: find walks the trie from the root one level per key bit; add
//   walks the existing levels, then creates the missing nodes; remove walks
//   down, clears a matching action, then frees empty leaves on the way up.
// Throughput: one operation at a time, each level costs a node ram read and a
//   decode step; a new request is taken only after the result of the last one
//   is loaded into the output register.
// Reset: synchronous; root empty and free list full at once, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_trie_longest_prefix_match #(
  parameter int NODE_POOL = 1024
) (
  input logic       clk,
  input logic       rst_n,
  blpm_in_if.sink   in_s,
  blpm_out_if.source out_s
);

  localparam int IW = $clog2(NODE_POOL);
  localparam int EW = 8 + 2 * IW;
  localparam int KB = blpm_pkg::KEY_BITS;
  localparam int LW = blpm_pkg::LVL_W;

  blpm_pkg::state_t  state_r, state_nxt;
  blpm_pkg::mode_t   mode_r, mode_nxt;
  blpm_pkg::status_t status_r, status_nxt;
  logic [KB-1:0] addr_r, addr_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]    act_r, act_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [7:0]    found_r, found_nxt;
  logic [LW-1:0] depth_r, depth_nxt;

  logic [IW-1:0] cur_idx_r, cur_idx_nxt;
  logic [7:0]    cur_act_r, cur_act_nxt;
  logic [IW-1:0] cur_k0_r, cur_k0_nxt;
  logic [IW-1:0] cur_k1_r, cur_k1_nxt;
  logic [IW-1:0] par_idx_r, par_idx_nxt;

  logic [7:0]    root_act_r;
  logic [IW-1:0] root_k0_r, root_k1_r;

  logic [IW-1:0] top_r, top_nxt;
  logic [IW-1:0] wm_r, wm_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          pop_init_r, pop_init_nxt;
  logic [IW-1:0] pop_val_r, pop_val_nxt;

  logic [IW-1:0] path_r [KB];
  logic          path_we;
  logic [blpm_pkg::PATH_W-1:0] path_wa;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_found_r, out_found_nxt;
  logic [5:0]    out_depth_r, out_depth_nxt;
  logic [9:0]    out_count_r, out_count_nxt;

  // node write request, root held in flops
  logic          nw_en;
  logic [IW-1:0] nw_idx;
  logic [7:0]    nw_act;
  logic [IW-1:0] nw_k0, nw_k1;
  logic [IW-1:0] node_ra;
  logic [EW-1:0] node_q;

  logic          stk_we;
  logic [IW-1:0] stk_wa, stk_wd, stk_ra, stk_q;

  logic          cur_bit, up_bit;
  logic [IW-1:0] cur_kid, pop_n, pop_pos;
  logic [7:0]    p_act;
  logic [IW-1:0] p_k0, p_k1;
  logic [LW-1:0] in_len;

  assign cur_bit = blpm_pkg::key_bit(addr_r, lvl_r);
  assign up_bit  = blpm_pkg::key_bit(addr_r, lvl_r - LW'(1));
  assign cur_kid = cur_bit ? cur_k1_r : cur_k0_r;
  assign pop_n   = pop_init_r ? pop_val_r : stk_q;
  assign pop_pos = top_r - IW'(1);
  assign in_len  = (in_s.prefix_len > LW'(KB)) ? LW'(KB) : in_s.prefix_len;

  // parent entry as read back during the upward pass
  assign p_act = (par_idx_r == '0) ? root_act_r : node_q[EW-1 -: 8];
  assign p_k1  = (par_idx_r == '0) ? root_k1_r  : node_q[2*IW-1 -: IW];
  assign p_k0  = (par_idx_r == '0) ? root_k0_r  : node_q[IW-1:0];

  assign in_s.ready         = (state_r == blpm_pkg::S_IDLE);
  assign out_s.valid        = out_valid_r;
  assign out_s.status       = out_status_r;
  assign out_s.found_action = out_found_r;
  assign out_s.match_depth  = out_depth_r;
  assign out_s.node_count   = out_count_r;

  // node store and free stack
  blpm_ram #(.WIDTH(EW), .DEPTH(NODE_POOL)) u_node_ram (
    .clk (clk),
    .we  (nw_en && (nw_idx != '0)),
    .wa  (nw_idx),
    .wd  ({nw_act, nw_k1, nw_k0}),
    .ra  (node_ra),
    .rd  (node_q)
  );

  blpm_ram #(.WIDTH(IW), .DEPTH(NODE_POOL)) u_stk_ram (
    .clk (clk),
    .we  (stk_we),
    .wa  (stk_wa),
    .wd  (stk_wd),
    .ra  (stk_ra),
    .rd  (stk_q)
  );

  // sequencer: next state and datapath
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    act_nxt        = act_r;
    lvl_nxt        = lvl_r;
    found_nxt      = found_r;
    depth_nxt      = depth_r;
    cur_idx_nxt    = cur_idx_r;
    cur_act_nxt    = cur_act_r;
    cur_k0_nxt     = cur_k0_r;
    cur_k1_nxt     = cur_k1_r;
    par_idx_nxt    = par_idx_r;
    top_nxt        = top_r;
    wm_nxt         = wm_r;
    cnt_nxt        = cnt_r;
    pop_init_nxt   = pop_init_r;
    pop_val_nxt    = pop_val_r;
    path_we        = 1'b0;
    path_wa        = lvl_r[blpm_pkg::PATH_W-1:0];
    nw_en          = 1'b0;
    nw_idx         = cur_idx_r;
    nw_act         = cur_act_r;
    nw_k0          = cur_k0_r;
    nw_k1          = cur_k1_r;
    node_ra        = cur_kid;
    stk_we         = 1'b0;
    stk_wa         = top_r;
    stk_wd         = cur_idx_r;
    stk_ra         = pop_pos;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_depth_nxt  = out_depth_r;
    out_count_nxt  = out_count_r;

    if (out_valid_r && out_s.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      blpm_pkg::S_IDLE: begin
        if (in_s.valid) begin
          mode_nxt    = blpm_pkg::mode_t'(in_s.mode);
          addr_nxt    = in_s.address;
          len_nxt     = in_len;
          act_nxt     = in_s.action;
          lvl_nxt     = '0;
          found_nxt   = blpm_pkg::NO_ACTION;
          depth_nxt   = '0;
          status_nxt  = blpm_pkg::ST_MISS;
          cur_idx_nxt = '0;
          cur_act_nxt = root_act_r;
          cur_k0_nxt  = root_k0_r;
          cur_k1_nxt  = root_k1_r;
          case (blpm_pkg::mode_t'(in_s.mode))
            blpm_pkg::MODE_FIND: state_nxt = blpm_pkg::S_WALK;
            blpm_pkg::MODE_ADD, blpm_pkg::MODE_REMOVE: begin
              if (in_len == '0) begin
                status_nxt = blpm_pkg::ST_IGNORED;
                state_nxt  = blpm_pkg::S_DONE;
              end else begin
                state_nxt = blpm_pkg::S_WALK;
              end
            end
            default: state_nxt = blpm_pkg::S_DONE;
          endcase
        end
      end

      blpm_pkg::S_WALK: begin
        case (mode_r)
          blpm_pkg::MODE_FIND: begin
            if (cur_act_r != blpm_pkg::NO_ACTION) begin
              found_nxt  = cur_act_r;
              depth_nxt  = lvl_r;
              status_nxt = blpm_pkg::ST_OK;
            end
            if (lvl_r < LW'(KB) && cur_kid != '0) begin
              cur_idx_nxt = cur_kid;
              lvl_nxt     = lvl_r + LW'(1);
              state_nxt   = blpm_pkg::S_FETCH;
            end else begin
              state_nxt = blpm_pkg::S_DONE;
            end
          end
          blpm_pkg::MODE_ADD: begin
            if (lvl_r < len_r && cur_kid != '0) begin
              cur_idx_nxt = cur_kid;
              lvl_nxt     = lvl_r + LW'(1);
              state_nxt   = blpm_pkg::S_FETCH;
            end else if (IW'(len_r - lvl_r) > top_r) begin
              status_nxt = blpm_pkg::ST_FULL;
              state_nxt  = blpm_pkg::S_DONE;
            end else if (lvl_r == len_r) begin
              // target exists, overwrite its action
              nw_en      = 1'b1;
              nw_act     = act_r;
              status_nxt = blpm_pkg::ST_OK;
              state_nxt  = blpm_pkg::S_DONE;
            end else begin
              state_nxt = blpm_pkg::S_POP;
            end
          end
          blpm_pkg::MODE_REMOVE: begin
            if (lvl_r < len_r && cur_kid != '0) begin
              path_we     = 1'b1;
              cur_idx_nxt = cur_kid;
              lvl_nxt     = lvl_r + LW'(1);
              state_nxt   = blpm_pkg::S_FETCH;
            end else begin
              if (lvl_r == len_r && cur_act_r == act_r) begin
                cur_act_nxt = blpm_pkg::NO_ACTION;
                nw_en       = 1'b1;
                nw_act      = blpm_pkg::NO_ACTION;
                status_nxt  = blpm_pkg::ST_OK;
              end
              state_nxt = blpm_pkg::S_UP;
            end
          end
          default: state_nxt = blpm_pkg::S_DONE;
        endcase
      end

      blpm_pkg::S_FETCH: begin
        cur_act_nxt = node_q[EW-1 -: 8];
        cur_k1_nxt  = node_q[2*IW-1 -: IW];
        cur_k0_nxt  = node_q[IW-1:0];
        state_nxt   = blpm_pkg::S_WALK;
      end

      // read the free stack top, entries below the watermark are untouched
      blpm_pkg::S_POP: begin
        pop_init_nxt = (pop_pos < wm_r);
        pop_val_nxt  = IW'(NODE_POOL - 1) - pop_pos;
        state_nxt    = blpm_pkg::S_CREATE;
      end

      blpm_pkg::S_CREATE: begin
        nw_en = 1'b1;
        if (cur_bit) begin
          nw_k1 = pop_n;
        end else begin
          nw_k0 = pop_n;
        end
        top_nxt     = pop_pos;
        wm_nxt      = (pop_pos < wm_r) ? pop_pos : wm_r;
        cnt_nxt     = cnt_r + IW'(1);
        cur_idx_nxt = pop_n;
        cur_k0_nxt  = '0;
        cur_k1_nxt  = '0;
        lvl_nxt     = lvl_r + LW'(1);
        if (lvl_r + LW'(1) == len_r) begin
          cur_act_nxt = act_r;
          state_nxt   = blpm_pkg::S_FIN;
        end else begin
          cur_act_nxt = blpm_pkg::NO_ACTION;
          state_nxt   = blpm_pkg::S_POP;
        end
      end

      blpm_pkg::S_FIN: begin
        nw_en      = 1'b1;
        status_nxt = blpm_pkg::ST_OK;
        state_nxt  = blpm_pkg::S_DONE;
      end

      // free empty leaves upward along the recorded path
      blpm_pkg::S_UP: begin
        if (lvl_r == '0 || cur_k0_r != '0 || cur_k1_r != '0 ||
            cur_act_r != blpm_pkg::NO_ACTION) begin
          state_nxt = blpm_pkg::S_DONE;
        end else begin
          if (lvl_r == LW'(1)) begin
            par_idx_nxt = '0;
            node_ra     = '0;
          end else begin
            par_idx_nxt = path_r[blpm_pkg::PATH_W'(lvl_r - LW'(2))];
            node_ra     = path_r[blpm_pkg::PATH_W'(lvl_r - LW'(2))];
          end
          state_nxt = blpm_pkg::S_UPLD;
        end
      end

      blpm_pkg::S_UPLD: begin
        nw_en       = 1'b1;
        nw_idx      = par_idx_r;
        nw_act      = p_act;
        nw_k0       = up_bit ? p_k0 : '0;
        nw_k1       = up_bit ? '0 : p_k1;
        stk_we      = 1'b1;
        top_nxt     = top_r + IW'(1);
        cnt_nxt     = cnt_r - IW'(1);
        cur_idx_nxt = par_idx_r;
        cur_act_nxt = p_act;
        cur_k0_nxt  = up_bit ? p_k0 : '0;
        cur_k1_nxt  = up_bit ? '0 : p_k1;
        lvl_nxt     = lvl_r - LW'(1);
        state_nxt   = blpm_pkg::S_UP;
      end

      blpm_pkg::S_DONE: begin
        if (!out_valid_r || out_s.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_depth_nxt  = depth_r;
          out_count_nxt  = 10'(cnt_r);
          state_nxt      = blpm_pkg::S_IDLE;
        end
      end

      default: state_nxt = blpm_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blpm_pkg::S_IDLE;
      top_r       <= IW'(NODE_POOL - 1);
      wm_r        <= IW'(NODE_POOL - 1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      root_act_r  <= blpm_pkg::NO_ACTION;
      root_k0_r   <= '0;
      root_k1_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      wm_r        <= wm_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (nw_en && nw_idx == '0) begin
        root_act_r <= nw_act;
        root_k0_r  <= nw_k0;
        root_k1_r  <= nw_k1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    status_r     <= status_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    act_r        <= act_nxt;
    lvl_r        <= lvl_nxt;
    found_r      <= found_nxt;
    depth_r      <= depth_nxt;
    cur_idx_r    <= cur_idx_nxt;
    cur_act_r    <= cur_act_nxt;
    cur_k0_r     <= cur_k0_nxt;
    cur_k1_r     <= cur_k1_nxt;
    par_idx_r    <= par_idx_nxt;
    pop_init_r   <= pop_init_nxt;
    pop_val_r    <= pop_val_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_depth_r  <= out_depth_nxt;
    out_count_r  <= out_count_nxt;
    if (path_we) begin
      path_r[path_wa] <= cur_kid;
    end
  end

  // every non-root node is either in use or on the free stack
  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} + {1'b0, top_r}) == (IW + 1)'(NODE_POOL - 1))
    else $error("node pool count and free stack out of step");

  // the walk never goes below the key length
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != blpm_pkg::S_IDLE) |-> (lvl_r <= LW'(KB)))
    else $error("trie level beyond key length");

  // a reported action always comes with an OK status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r != blpm_pkg::NO_ACTION) |->
      (out_status_r == blpm_pkg::ST_OK))
    else $error("action reported without a match");

endmodule
